/* src/kal_pkg.sv */
// ----------------------------------------------------------------------------
// kal_pkg
// Shared types and constants for the binary lifting ancestor block.
// ----------------------------------------------------------------------------
package kal_pkg;

  localparam int ID_W = 18;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_WRITE,
    ST_QUERY,
    ST_HOLD
  } state_t;

endpackage

/* src/kal_table.sv */
// ----------------------------------------------------------------------------
// kal_table
// Jump table memory, one row of all levels per node, registered read.
// ----------------------------------------------------------------------------
module kal_table #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18,
  parameter int DW    = 324
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/kal_step.sv */
// ----------------------------------------------------------------------------
// kal_step
// One lifting step: picks a level from the row just read, with range guard
// and a bypass for the row still being built.
// ----------------------------------------------------------------------------
module kal_step import kal_pkg::*; #(
  parameter int MAX_NODES = 262144,
  parameter int LEVELS    = 18,
  parameter int LW        = 5
) (
  input  logic [ID_W-1:0]              cur,
  input  logic                         self_hit,
  input  logic [LW-1:0]                col,
  input  logic [LEVELS-1:0][ID_W-1:0]  row,
  output logic [ID_W-1:0]              jump
);

  logic in_range;

  assign in_range = (cur != '0) && (32'(cur) < 32'(MAX_NODES));

  always_comb begin
    if (!in_range) begin
      jump = '0;
    end else if (self_hit) begin
      jump = cur;
    end else begin
      jump = row[col];
    end
  end

endmodule

/* src/kal_ctrl.sv */
// ----------------------------------------------------------------------------
// kal_ctrl
// Sequencer: clearing sweep, row build for loads, bit walk for queries,
// result register.
// ----------------------------------------------------------------------------
module kal_ctrl import kal_pkg::*; #(
  parameter int MAX_NODES = 262144,
  parameter int LEVELS    = 18,
  parameter int AW        = 18,
  parameter int LW        = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic                         opcode,
  input  logic [ID_W-1:0]              node_id,
  input  logic [ID_W-1:0]              parent_id,
  input  logic [ID_W-1:0]              jump_count,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [ID_W-1:0]              ancestor_id,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [LEVELS-1:0][ID_W-1:0]  mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  logic [LEVELS-1:0][ID_W-1:0]  mem_rdata
);

  state_t                       state, state_next;
  logic [AW-1:0]                clr_cnt;
  logic [ID_W-1:0]              cur;
  logic [ID_W-1:0]              node_reg;
  logic [LW-1:0]                lvl;
  logic [LEVELS-1:0]            cnt_sh;
  logic [LEVELS-1:0][ID_W-1:0]  build;

  logic            cmd_acc;
  logic            is_query;
  logic            too_high;
  logic            node_ok;
  logic            res_free;
  logic            push;
  logic            self_hit;
  logic [LW-1:0]   step_col;
  logic [ID_W-1:0] jv;
  logic [ID_W-1:0] nxt;

  assign cmd_acc  = cmd_valid && !cmd_stall;
  assign is_query = (op_t'(opcode) == OP_QUERY);
  assign too_high = (32'(jump_count) >> LEVELS) != 32'd0;
  assign node_ok  = (node_id != '0) && (32'(node_id) < 32'(MAX_NODES));
  assign res_free = !res_valid || !res_stall;
  assign self_hit = (state == ST_LOAD) && (cur == node_reg);
  assign step_col = (state == ST_LOAD) ? lvl - LW'(1) : lvl;

  kal_step #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS),
    .LW        (LW)
  ) u_step (
    .cur      (cur),
    .self_hit (self_hit),
    .col      (step_col),
    .row      (mem_rdata),
    .jump     (jv)
  );

  assign nxt = ((state == ST_LOAD) || cnt_sh[LEVELS-1]) ? jv : cur;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(MAX_NODES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_acc) begin
          if (is_query) begin
            state_next = ((jump_count == '0) || too_high) ? ST_HOLD : ST_QUERY;
          end else if (node_ok) begin
            state_next = (LEVELS == 1) ? ST_WRITE : ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (lvl == LW'(LEVELS - 1)) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_QUERY: begin
        if (lvl == '0) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_stall = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = AW'(node_reg);
    mem_wdata = build;
    mem_raddr = AW'(nxt);
    push      = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        cmd_stall = 1'b0;
        mem_raddr = is_query ? AW'(node_id) : AW'(parent_id);
      end
      ST_WRITE: mem_we = 1'b1;
      ST_HOLD:  push = res_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (push) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ancestor_id <= cur;
    end
    case (state)
      ST_IDLE: begin
        if (cmd_acc) begin
          node_reg <= node_id;
          if (is_query) begin
            cur    <= ((jump_count != '0) && too_high) ? '0 : node_id;
            lvl    <= LW'(LEVELS - 1);
            cnt_sh <= LEVELS'(jump_count);
          end else begin
            cur      <= parent_id;
            build[0] <= parent_id;
            lvl      <= LW'(1);
          end
        end
      end
      ST_LOAD: begin
        build[lvl] <= jv;
        cur        <= jv;
        lvl        <= lvl + LW'(1);
      end
      ST_QUERY: begin
        cur    <= nxt;
        lvl    <= lvl - LW'(1);
        cnt_sh <= cnt_sh << 1;
      end
      default: ;
    endcase
  end

endmodule

/* src/kth_ancestor_binary_lifting.sv */
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting
// Binary lifting jump table with node loads and k-th ancestor queries.
// ----------------------------------------------------------------------------
// usage
//   command channel cmd_valid / cmd_stall carries opcode, node_id, parent_id
//   and jump_count; a load stores a node's parent and builds its row, a
//   query returns the ancestor jump_count levels up on res_valid / res_stall
//   as ancestor_id (0 when the climb passes the root)
//   after reset the table is swept to zero, one row a cycle, through all
//   MAX_NODES rows; cmd_stall stays high throughout
//   a load occupies the block for one dependent table read per level
//   through the single read port, then one row write
//   a load with node 0 or out of range is dropped; the block stays idle
//   a query walks all LEVELS bits of the count, one table read per level,
//   then its result is registered as ancestor_id on leaving the hold state
//   (the walk is skipped when the count is zero or beyond the table)
//   one transaction at a time; a finished result waits in the output
//   register while the next command is accepted; if that register is still
//   stalled when the next query ends, the sequencer holds until it frees
// ----------------------------------------------------------------------------
module kth_ancestor_binary_lifting import kal_pkg::*; #(
  parameter int MAX_NODES = 262144,
  parameter int LEVELS    = 18
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  logic            opcode,
  input  logic [ID_W-1:0] node_id,
  input  logic [ID_W-1:0] parent_id,
  input  logic [ID_W-1:0] jump_count,
  output logic            res_valid,
  input  logic            res_stall,
  output logic [ID_W-1:0] ancestor_id
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DW = LEVELS * ID_W;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [LEVELS-1:0][ID_W-1:0]  mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [LEVELS-1:0][ID_W-1:0]  mem_rdata;

  kal_ctrl #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS),
    .AW        (AW),
    .LW        (LW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .opcode      (opcode),
    .node_id     (node_id),
    .parent_id   (parent_id),
    .jump_count  (jump_count),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .ancestor_id (ancestor_id),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  kal_table #(
    .DEPTH (MAX_NODES),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* src/kal_check.sv */
// ----------------------------------------------------------------------------
// kal_check
// Port-level checks for the ancestor block, bound to the top level.
// ----------------------------------------------------------------------------
module kal_check import kal_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_stall,
  input logic            opcode,
  input logic [ID_W-1:0] node_id,
  input logic [ID_W-1:0] jump_count,
  input logic            res_valid,
  input logic            res_stall,
  input logic [ID_W-1:0] ancestor_id
);

  logic cmd_acc;
  logic is_query;

  assign cmd_acc  = cmd_valid && !cmd_stall;
  assign is_query = (op_t'(opcode) == OP_QUERY);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(ancestor_id))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid && cmd_stall)
    else $error("block not quiet after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && is_query |=> cmd_stall)
    else $error("query accepted without going busy");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && !is_query && !res_valid |=> !res_valid ##1 !res_valid)
    else $error("load produced a result");

  a_zero_jump: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && is_query && (jump_count == '0) && !res_valid
    |-> ##2 (res_valid && (ancestor_id == $past(node_id, 2))))
    else $error("zero jump did not return the node itself");

endmodule

bind kth_ancestor_binary_lifting kal_check u_check (.*);
